@@ sv/svm_pkg.sv @@
// Shared types, constants and microcode for the sample voice mixer.
// No dependencies; svm_in_if and the top level refer to it by scoped names.
`default_nettype none

package svm_pkg;

    localparam int SAMPLE_DEPTH    = 4096;
    localparam int TICKS_PER_FRAME = 441;
    localparam int PHASE_FRAC_BITS = 16;

    localparam int ADDR_W   = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int STEP_W   = 24;
    localparam int VOL_W    = 7;
    localparam int FRM_CFG_W = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int TICK_W   = $clog2(TICKS_PER_FRAME);
    localparam int FRAME_W  = FRM_CFG_W + 1;

    localparam int PHASE_W  = ((PHASE_FRAC_BITS + ADDR_W > STEP_W) ?
                               PHASE_FRAC_BITS + ADDR_W : STEP_W) + 1;
    localparam int IP_W     = PHASE_W - PHASE_FRAC_BITS;
    localparam int MAG_W    = 14;
    localparam int DQ_W     = MAG_W + FRM_CFG_W;
    localparam int REM_W    = ((IP_W > FRM_CFG_W) ? IP_W : FRM_CFG_W) + 1;
    localparam int CNT_W    = $clog2(DQ_W + 1);

    // commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_FRAMES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd5;

    localparam logic [STEP_W-1:0]    RST_PHASE_STEP = 24'd65536;
    localparam logic [LEN_W-1:0]     RST_SAMPLE_LEN = LEN_W'(8);
    localparam logic [VOL_W-1:0]     RST_VOLUME     = 7'd64;
    localparam logic [FRM_CFG_W-1:0] RST_ENV_FRAMES = 8'd20;

    // microcode
    localparam int OP_W   = 4;
    localparam int COND_W = 3;
    localparam int PC_W   = 5;

    localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
    localparam logic [OP_W-1:0] OP_CHK_END     = 4'd1;
    localparam logic [OP_W-1:0] OP_END_ONESHOT = 4'd2;
    localparam logic [OP_W-1:0] OP_MOD_INIT    = 4'd3;
    localparam logic [OP_W-1:0] OP_DSTEP       = 4'd4;
    localparam logic [OP_W-1:0] OP_MOD_DONE    = 4'd5;
    localparam logic [OP_W-1:0] OP_RD          = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL1        = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL2        = 4'd8;
    localparam logic [OP_W-1:0] OP_MIX         = 4'd9;
    localparam logic [OP_W-1:0] OP_ADV         = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT         = 4'd11;

    localparam logic [COND_W-1:0] C_NEVER   = 3'd0;
    localparam logic [COND_W-1:0] C_SKIP    = 3'd1;
    localparam logic [COND_W-1:0] C_INRANGE = 3'd2;
    localparam logic [COND_W-1:0] C_ONESHOT = 3'd3;
    localparam logic [COND_W-1:0] C_MORE    = 3'd4;

    localparam logic [PC_W-1:0] L_MAC = 5'd7;
    localparam logic [PC_W-1:0] L_OUT = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    function automatic t_uword f_uw(input logic [OP_W-1:0] op,
                                    input logic [COND_W-1:0] cond,
                                    input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:    w = f_uw(OP_CHK_END,     C_NEVER,   '0);
            5'd1:    w = f_uw(OP_NOP,         C_SKIP,    L_OUT);
            5'd2:    w = f_uw(OP_NOP,         C_INRANGE, L_MAC);
            5'd3:    w = f_uw(OP_END_ONESHOT, C_ONESHOT, L_OUT);
            5'd4:    w = f_uw(OP_MOD_INIT,    C_NEVER,   '0);
            5'd5:    w = f_uw(OP_DSTEP,       C_MORE,    5'd5);
            5'd6:    w = f_uw(OP_MOD_DONE,    C_NEVER,   '0);
            5'd7:    w = f_uw(OP_RD,          C_NEVER,   '0);
            5'd8:    w = f_uw(OP_MUL1,        C_NEVER,   '0);
            5'd9:    w = f_uw(OP_MUL2,        C_NEVER,   '0);
            5'd10:   w = f_uw(OP_DSTEP,       C_MORE,    5'd10);
            5'd11:   w = f_uw(OP_MIX,         C_NEVER,   '0);
            5'd12:   w = f_uw(OP_ADV,         C_NEVER,   '0);
            5'd13:   w = f_uw(OP_NOP,         C_INRANGE, L_OUT);
            5'd14:   w = f_uw(OP_END_ONESHOT, C_ONESHOT, L_OUT);
            5'd15:   w = f_uw(OP_MOD_INIT,    C_NEVER,   '0);
            5'd16:   w = f_uw(OP_DSTEP,       C_MORE,    5'd16);
            5'd17:   w = f_uw(OP_MOD_DONE,    C_NEVER,   '0);
            5'd18:   w = f_uw(OP_OUT,         C_NEVER,   '0);
            default: w = f_uw(OP_OUT,         C_NEVER,   '0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/svm_in_if.sv @@
// Input channel of the sample voice mixer: valid/ready plus one command word.
// Depends on svm_pkg for field widths.
`default_nettype none

interface svm_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          command;
    logic [svm_pkg::ADDR_W-1:0]          sample_addr;
    logic signed [7:0]                   sample_byte;
    logic signed [15:0]                  mix_in;

    modport source (output valid, command, sample_addr, sample_byte, mix_in,
                    input ready);
    modport sink   (input valid, command, sample_addr, sample_byte, mix_in,
                    output ready);
endinterface

`default_nettype wire

@@ sv/svm_out_if.sv @@
// Output channel of the sample voice mixer: valid/ready plus one mix word.
// No dependencies.
`default_nettype none

interface svm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mix_out;
    logic               voice_active;

    modport source (output valid, mix_out, voice_active, input ready);
    modport sink   (input valid, mix_out, voice_active, output ready);
endinterface

`default_nettype wire

@@ sv/sample_voice_mixer.sv @@
// Sample voice mixer top level: microcoded sequencer, shared iterative divider,
// sample store. Depends on svm_pkg, svm_in_if and svm_out_if.
//
// Usage: words on i_in carry a command. A load writes one sample byte into
// the 4096-entry store and a restart rearms the voice; both leave the input
// ready and give no output word. A tick carries the current mix sample and
// gives exactly one word on o_out: the mix plus this voice's contribution,
// and the voice_active flag.
// A tick runs a short microprogram; the input is not ready while it runs.
// Work of a tick: only the output step when the voice is idle or delayed;
// a sample read and envelope scaling when it plays with its phase in range;
// a phase wrap before and after the advance as well when the phase leaves
// the sample range. The shared shift-subtract divider takes 22 steps for the
// envelope scaling and 13 steps for each phase wrap.
// Configuration writes on i_cfg_we update the registers directly, also during a running tick.
// Reset (synchronous, i_rst_n low) restores register defaults, idles the
// voice and empties the output register; the store keeps its contents.
// When o_out stalls, the finished word waits in the output register; a new
// tick may be accepted and runs up to its output step, then waits there.
`default_nettype none

module sample_voice_mixer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    svm_in_if.sink                          i_in,
    svm_out_if.source                       o_out,
    input  wire                             i_cfg_we,
    input  wire [svm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [svm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int FRAC = svm_pkg::PHASE_FRAC_BITS;

    // configuration
    logic [svm_pkg::STEP_W-1:0]    r_step;
    logic [svm_pkg::LEN_W-1:0]     r_len;
    logic                          r_loop;
    logic [svm_pkg::VOL_W-1:0]     r_volume;
    logic [svm_pkg::FRM_CFG_W-1:0] r_env;
    logic [svm_pkg::FRM_CFG_W-1:0] r_delay;

    // voice state
    logic [svm_pkg::PHASE_W-1:0]   r_phase;
    logic [svm_pkg::TICK_W-1:0]    r_tick;
    logic [svm_pkg::FRAME_W-1:0]   r_frame;
    logic                          r_active;
    logic                          r_contrib;

    // sequencer
    logic                          r_busy;
    logic [svm_pkg::PC_W-1:0]      r_pc;
    logic [svm_pkg::CNT_W-1:0]     r_cnt;
    svm_pkg::t_uword               uw;
    logic                          step_go;
    logic                          cond_hit;

    // datapath
    logic signed [7:0]             r_samp;
    logic                          r_neg;
    logic [svm_pkg::MAG_W-1:0]     r_mag;
    logic [svm_pkg::DQ_W-1:0]      r_quo;
    logic [svm_pkg::REM_W-1:0]     r_rem;
    logic                          r_dsel;
    logic signed [15:0]            r_mix;

    logic                          r_ovalid;
    logic signed [15:0]            r_omix;
    logic                          r_oact;

    logic signed [7:0]             r_mem [svm_pkg::SAMPLE_DEPTH];

    logic [svm_pkg::LEN_W-1:0]     len_eff;
    logic [svm_pkg::IP_W-1:0]      ip;
    logic                          in_range;
    logic [svm_pkg::FRAME_W-1:0]   end_frame;
    logic [svm_pkg::FRM_CFG_W-1:0] env_left;
    logic [svm_pkg::REM_W-1:0]     dsor;
    logic [svm_pkg::REM_W-1:0]     trial;
    logic                          n_qbit;
    logic [svm_pkg::REM_W-1:0]     n_rem;
    logic signed [15:0]            prod1;
    logic [15:0]                   q16;
    logic                          in_acc;
    logic                          voiced;

    assign uw      = svm_pkg::f_ucode(r_pc);
    assign in_acc  = i_in.valid && i_in.ready;
    assign step_go = r_busy && !(uw.op == svm_pkg::OP_OUT && r_ovalid && !o_out.ready);

    assign i_in.ready         = !r_busy;
    assign o_out.valid        = r_ovalid;
    assign o_out.mix_out      = r_omix;
    assign o_out.voice_active = r_oact;

    always_comb begin
        if (r_len == '0) begin
            len_eff = svm_pkg::LEN_W'(1);
        end else if (r_len > svm_pkg::LEN_W'(svm_pkg::SAMPLE_DEPTH)) begin
            len_eff = svm_pkg::LEN_W'(svm_pkg::SAMPLE_DEPTH);
        end else begin
            len_eff = r_len;
        end
    end

    assign ip        = r_phase[svm_pkg::PHASE_W-1:FRAC];
    assign in_range  = ip < svm_pkg::IP_W'(len_eff);
    assign end_frame = svm_pkg::FRAME_W'(r_delay) + svm_pkg::FRAME_W'(r_env);
    assign env_left  = r_env - svm_pkg::FRM_CFG_W'(r_frame - svm_pkg::FRAME_W'(r_delay));
    assign voiced    = r_active || r_contrib;

    // shift-subtract step, shared by phase wrap and envelope scaling
    assign dsor   = r_dsel ? svm_pkg::REM_W'(r_env) : svm_pkg::REM_W'(len_eff);
    assign trial  = {r_rem[svm_pkg::REM_W-2:0], r_quo[svm_pkg::DQ_W-1]};
    assign n_qbit = trial >= dsor;
    assign n_rem  = n_qbit ? trial - dsor : trial;

    assign prod1 = 16'(r_samp) * $signed(16'(r_volume));
    assign q16   = r_quo[15:0];

    always_comb begin
        unique case (uw.cond)
            svm_pkg::C_NEVER:   cond_hit = 1'b0;
            svm_pkg::C_SKIP:    cond_hit = !r_active || (r_frame < svm_pkg::FRAME_W'(r_delay));
            svm_pkg::C_INRANGE: cond_hit = in_range;
            svm_pkg::C_ONESHOT: cond_hit = !r_loop;
            svm_pkg::C_MORE:    cond_hit = r_cnt != svm_pkg::CNT_W'(1);
            default:            cond_hit = 1'b0;
        endcase
    end

    // control and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= svm_pkg::RST_PHASE_STEP;
            r_len     <= svm_pkg::RST_SAMPLE_LEN;
            r_loop    <= 1'b0;
            r_volume  <= svm_pkg::RST_VOLUME;
            r_env     <= svm_pkg::RST_ENV_FRAMES;
            r_delay   <= '0;
            r_phase   <= '0;
            r_tick    <= '0;
            r_frame   <= '0;
            r_active  <= 1'b0;
            r_contrib <= 1'b0;
            r_busy    <= 1'b0;
            r_pc      <= '0;
            r_cnt     <= '0;
            r_dsel    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    svm_pkg::REG_PHASE_STEP: r_step   <= i_cfg_data[svm_pkg::STEP_W-1:0];
                    svm_pkg::REG_SAMPLE_LEN: r_len    <= i_cfg_data[svm_pkg::LEN_W-1:0];
                    svm_pkg::REG_LOOP_EN:    r_loop   <= i_cfg_data[0];
                    svm_pkg::REG_VOLUME:     r_volume <= i_cfg_data[svm_pkg::VOL_W-1:0];
                    svm_pkg::REG_ENV_FRAMES: r_env    <= i_cfg_data[svm_pkg::FRM_CFG_W-1:0];
                    svm_pkg::REG_DELAY:      r_delay  <= i_cfg_data[svm_pkg::FRM_CFG_W-1:0];
                    default: ;
                endcase
            end

            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            if (in_acc) begin
                unique case (i_in.command)
                    svm_pkg::CMD_RESTART: begin
                        r_phase  <= '0;
                        r_tick   <= '0;
                        r_frame  <= '0;
                        r_active <= 1'b1;
                    end
                    svm_pkg::CMD_TICK: begin
                        r_busy <= 1'b1;
                        r_pc   <= '0;
                    end
                    default: ;
                endcase
            end

            if (step_go) begin
                r_pc <= cond_hit ? uw.target : r_pc + svm_pkg::PC_W'(1);
                unique case (uw.op)
                    svm_pkg::OP_CHK_END: begin
                        r_contrib <= 1'b0;
                        if (r_active && r_frame >= end_frame) begin
                            r_active <= 1'b0;
                            r_phase  <= '0;
                        end
                    end
                    svm_pkg::OP_END_ONESHOT: begin
                        if (!r_loop) begin
                            r_active <= 1'b0;
                            r_phase  <= '0;
                        end
                    end
                    svm_pkg::OP_MOD_INIT: begin
                        r_cnt  <= svm_pkg::CNT_W'(svm_pkg::IP_W);
                        r_dsel <= 1'b0;
                    end
                    svm_pkg::OP_DSTEP: begin
                        r_cnt <= r_cnt - svm_pkg::CNT_W'(1);
                    end
                    svm_pkg::OP_MOD_DONE: begin
                        r_phase <= svm_pkg::PHASE_W'({r_rem[svm_pkg::ADDR_W-1:0],
                                                      r_phase[FRAC-1:0]});
                    end
                    svm_pkg::OP_MUL2: begin
                        r_cnt  <= svm_pkg::CNT_W'(svm_pkg::DQ_W);
                        r_dsel <= 1'b1;
                    end
                    svm_pkg::OP_MIX: begin
                        r_contrib <= 1'b1;
                    end
                    svm_pkg::OP_ADV: begin
                        r_phase <= r_phase + svm_pkg::PHASE_W'(r_step);
                    end
                    svm_pkg::OP_OUT: begin
                        r_busy   <= 1'b0;
                        r_ovalid <= 1'b1;
                        if (voiced) begin
                            if (r_tick == svm_pkg::TICK_W'(svm_pkg::TICKS_PER_FRAME - 1)) begin
                                r_tick  <= '0;
                                r_frame <= r_frame + svm_pkg::FRAME_W'(1);
                            end else begin
                                r_tick <= r_tick + svm_pkg::TICK_W'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.command == svm_pkg::CMD_TICK) begin
            r_mix <= i_in.mix_in;
        end
        if (step_go) begin
            unique case (uw.op)
                svm_pkg::OP_MOD_INIT: begin
                    r_quo <= {ip, {(svm_pkg::DQ_W - svm_pkg::IP_W){1'b0}}};
                    r_rem <= '0;
                end
                svm_pkg::OP_DSTEP: begin
                    r_quo <= {r_quo[svm_pkg::DQ_W-2:0], n_qbit};
                    r_rem <= n_rem;
                end
                svm_pkg::OP_MUL1: begin
                    r_neg <= prod1[15];
                    r_mag <= prod1[15] ? svm_pkg::MAG_W'(-prod1) : svm_pkg::MAG_W'(prod1);
                end
                svm_pkg::OP_MUL2: begin
                    r_quo <= svm_pkg::DQ_W'(r_mag) * svm_pkg::DQ_W'(env_left);
                    r_rem <= '0;
                end
                svm_pkg::OP_MIX: begin
                    r_mix <= r_mix + $signed(r_neg ? -q16 : q16);
                end
                svm_pkg::OP_OUT: begin
                    r_omix <= r_mix;
                    r_oact <= voiced;
                end
                default: ;
            endcase
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.command == svm_pkg::CMD_LOAD) begin
            r_mem[i_in.sample_addr] <= i_in.sample_byte;
        end
        if (step_go && uw.op == svm_pkg::OP_RD) begin
            r_samp <= r_mem[r_phase[FRAC+svm_pkg::ADDR_W-1:FRAC]];
        end
    end

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < svm_pkg::TICK_W'(svm_pkg::TICKS_PER_FRAME))
        else $error("tick counter out of frame");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= svm_pkg::FRAME_W'(2 * (2 ** svm_pkg::FRM_CFG_W - 1)))
        else $error("frame counter beyond delay plus envelope");

    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && uw.op == svm_pkg::OP_MOD_DONE) |=> in_range)
        else $error("wrapped phase outside sample");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(step_go && uw.op == svm_pkg::OP_OUT))
        else $error("output word not from output step");

    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && uw.op == svm_pkg::OP_OUT) |=> (!r_busy && r_ovalid))
        else $error("output step did not finish the tick");

endmodule

`default_nettype wire
